// ----- hdl/tfrp_pkg.sv -----
`default_nettype none

package tfrp_pkg;

  // Width of the line counter; the line_index port shows its low 16 bits.
  localparam int LINE_INDEX_BITS = 16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef enum logic [3:0] {
    PH_SKIP  = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } num_phase_t;

  typedef enum logic [2:0] {
    FP_FLAG = 3'b001,
    FP_QUAL = 3'b010,
    FP_TEXT = 3'b100
  } field_pos_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] text_byte;
    logic       end_of_block;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  text_out;
    logic [15:0] flag_value;
    logic [7:0]  quality_value;
    logic [15:0] line_index;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/tfrp_in_stage.sv -----
`default_nettype none

module tfrp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    text_byte,
  input  wire logic          end_of_block,
  input  wire logic          out_free,
  output tfrp_pkg::item_t    item,
  output logic               take
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_eob;
  logic       accept;

  assign take     = held_valid && out_free;
  assign in_stall = held_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= accept || (held_valid && !out_free);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= text_byte;
      held_eob  <= end_of_block;
    end
  end

  assign item = '{valid: held_valid, text_byte: held_byte, end_of_block: held_eob};

endmodule

`default_nettype wire

// ----- hdl/tfrp_parse.sv -----
`default_nettype none

module tfrp_parse (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tfrp_pkg::item_t item,
  input  wire logic            take,
  output logic                 emit,
  output tfrp_pkg::result_t    result
);

  tfrp_pkg::field_pos_t field_position, field_position_next;
  tfrp_pkg::num_phase_t number_phase, number_phase_next;
  logic [63:0] number_accumulator, number_accumulator_next;
  logic        number_overflow, number_overflow_next;
  logic        number_negative, number_negative_next;
  logic [15:0] held_flag, held_flag_next;
  logic [7:0]  held_quality, held_quality_next;
  logic [tfrp_pkg::LINE_INDEX_BITS-1:0] line_counter, line_counter_next;
  logic        segment_cut, segment_cut_next;

  logic [7:0]  b;
  logic        is_digit;
  logic        is_space;
  logic        is_sign;
  logic [7:0]  digit_wide;
  logic [67:0] scaled;
  logic [15:0] value_low;
  logic [31:0] counter_wide;

  assign b          = item.text_byte;
  assign is_digit   = (b >= tfrp_pkg::CH_ZERO) && (b <= tfrp_pkg::CH_NINE);
  assign is_space   = (b == tfrp_pkg::CH_SPACE) || (b == tfrp_pkg::CH_VT) ||
                      (b == tfrp_pkg::CH_FF) || (b == tfrp_pkg::CH_CR);
  assign is_sign    = (b == tfrp_pkg::CH_PLUS) || (b == tfrp_pkg::CH_MINUS);
  assign digit_wide = b - tfrp_pkg::CH_ZERO;
  // acc * 10 + digit as shift-and-add; any carry past bit 63 is overflow
  assign scaled     = {1'b0, number_accumulator, 3'b000} + {3'b000, number_accumulator, 1'b0}
                      + {64'd0, digit_wide[3:0]};
  assign value_low  = number_overflow ? 16'hFFFF :
                      number_negative ? (16'd0 - number_accumulator[15:0]) :
                      number_accumulator[15:0];
  assign counter_wide = 32'(line_counter);

  always_comb begin
    field_position_next     = field_position;
    number_phase_next       = number_phase;
    number_accumulator_next = number_accumulator;
    number_overflow_next    = number_overflow;
    number_negative_next    = number_negative;
    held_flag_next          = held_flag;
    held_quality_next       = held_quality;
    line_counter_next       = line_counter;
    segment_cut_next        = segment_cut;
    emit                    = 1'b0;
    result                  = '0;

    if (b == tfrp_pkg::CH_NL) begin
      emit                 = 1'b1;
      result.result_kind   = tfrp_pkg::KIND_RECORD;
      result.flag_value    = held_flag;
      result.quality_value = held_quality;
      result.line_index    = counter_wide[15:0];
      line_counter_next    = line_counter + 1'b1;
      field_position_next  = tfrp_pkg::FP_FLAG;
      held_flag_next       = '0;
      held_quality_next    = '0;
      segment_cut_next     = 1'b0;
      number_phase_next       = tfrp_pkg::PH_SKIP;
      number_accumulator_next = '0;
      number_overflow_next    = 1'b0;
      number_negative_next    = 1'b0;
    end else if (b == tfrp_pkg::CH_TAB) begin
      unique case (field_position)
        tfrp_pkg::FP_FLAG: begin
          held_flag_next      = value_low;
          field_position_next = tfrp_pkg::FP_QUAL;
        end
        tfrp_pkg::FP_QUAL: begin
          held_quality_next   = value_low[7:0];
          field_position_next = tfrp_pkg::FP_TEXT;
        end
        default: begin
          emit               = 1'b1;
          result.result_kind = tfrp_pkg::KIND_TEXT;
          result.text_out    = b;
        end
      endcase
      number_phase_next       = tfrp_pkg::PH_SKIP;
      number_accumulator_next = '0;
      number_overflow_next    = 1'b0;
      number_negative_next    = 1'b0;
      segment_cut_next        = 1'b0;
    end else if (field_position != tfrp_pkg::FP_TEXT) begin
      priority if (number_phase == tfrp_pkg::PH_SKIP && is_space) begin
        number_phase_next = number_phase;
      end else if (number_phase == tfrp_pkg::PH_SKIP && is_sign) begin
        number_negative_next = (b == tfrp_pkg::CH_MINUS);
        number_phase_next    = tfrp_pkg::PH_SIGN;
      end else if (number_phase != tfrp_pkg::PH_DONE && is_digit) begin
        if (scaled[67:64] != 4'd0) begin
          number_overflow_next = 1'b1;
        end else begin
          number_accumulator_next = scaled[63:0];
        end
        number_phase_next = tfrp_pkg::PH_DIGIT;
      end else begin
        number_phase_next = tfrp_pkg::PH_DONE;
      end
    end else if (b == tfrp_pkg::CH_NUL) begin
      segment_cut_next = 1'b1;
    end else if (!segment_cut) begin
      emit               = 1'b1;
      result.result_kind = tfrp_pkg::KIND_TEXT;
      result.text_out    = b;
    end

    // block end: drop all parse state and restart line numbering
    if (item.end_of_block) begin
      field_position_next     = tfrp_pkg::FP_FLAG;
      number_phase_next       = tfrp_pkg::PH_SKIP;
      number_accumulator_next = '0;
      number_overflow_next    = 1'b0;
      number_negative_next    = 1'b0;
      held_flag_next          = '0;
      held_quality_next       = '0;
      line_counter_next       = '0;
      segment_cut_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_position     <= tfrp_pkg::FP_FLAG;
      number_phase       <= tfrp_pkg::PH_SKIP;
      number_accumulator <= '0;
      number_overflow    <= 1'b0;
      number_negative    <= 1'b0;
      held_flag          <= '0;
      held_quality       <= '0;
      line_counter       <= '0;
      segment_cut        <= 1'b0;
    end else if (take) begin
      field_position     <= field_position_next;
      number_phase       <= number_phase_next;
      number_accumulator <= number_accumulator_next;
      number_overflow    <= number_overflow_next;
      number_negative    <= number_negative_next;
      held_flag          <= held_flag_next;
      held_quality       <= held_quality_next;
      line_counter       <= line_counter_next;
      segment_cut        <= segment_cut_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tfrp_out_stage.sv -----
`default_nettype none

module tfrp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire tfrp_pkg::result_t result,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tfrp_pkg::result_t      held
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tab_field_record_parser.sv -----
// Tab-separated record parser: one text byte in, at most one word out.
// Input channel: in_valid / in_stall with text_byte and end_of_block.
// A word is taken at a clock edge where in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with result_kind, text_out,
// flag_value, quality_value and line_index; a word leaves at an edge where
// out_valid is high and out_stall low.
// A taken byte is held in the input register and parsed from there; its
// result, if it has one (number bytes, the two tabs that close the number
// fields and dropped bytes have none), loads into the free output register.
// Throughput: one byte per cycle while out_stall is low; the loop through
// the parse state (the 64-bit multiply-by-ten add) is registered.
// Reset (rst, synchronous) empties both registers, clears the line counter
// and all parse state. The same parse state clears after a byte marked
// end_of_block.
// When out_stall is held, the output word holds, the input register takes
// one more byte if it is empty, and in_stall is high until the word leaves.
`default_nettype none

module tab_field_record_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [7:0]       text_out,
  output logic [15:0]      flag_value,
  output logic [7:0]       quality_value,
  output logic [15:0]      line_index
);

  tfrp_pkg::item_t   item;
  tfrp_pkg::result_t result;
  tfrp_pkg::result_t held;
  logic              take;
  logic              emit;
  logic              out_free;

  tfrp_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .end_of_block (end_of_block),
    .out_free     (out_free),
    .item         (item),
    .take         (take)
  );

  tfrp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .take   (take),
    .emit   (emit),
    .result (result)
  );

  tfrp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && emit),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign result_kind   = held.result_kind;
  assign text_out      = held.text_out;
  assign flag_value    = held.flag_value;
  assign quality_value = held.quality_value;
  assign line_index    = held.line_index;

endmodule

`default_nettype wire

// ----- hdl/tfrp_checker.sv -----
`default_nettype none

module tfrp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  text_byte,
  input wire logic        end_of_block,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        result_kind,
  input wire logic [7:0]  text_out,
  input wire logic [15:0] flag_value,
  input wire logic [7:0]  quality_value,
  input wire logic [15:0] line_index
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // input backs up only while an output word waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_text_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == tfrp_pkg::KIND_TEXT |->
      flag_value == 16'd0 && quality_value == 8'd0 && line_index == 16'd0)
    else $error("text word carries record fields");

  a_record_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == tfrp_pkg::KIND_RECORD |-> text_out == 8'd0)
    else $error("record word carries a text byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(text_out)
      && $stable(flag_value) && $stable(quality_value) && $stable(line_index))
    else $error("stalled output word changed");

endmodule

bind tab_field_record_parser tfrp_checker u_chk (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;

  typedef struct packed {
    logic [7:0] b;
    logic       eob;
  } byte_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  text_byte;
  logic        end_of_block;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [7:0]  text_out;
  logic [15:0] flag_value;
  logic [7:0]  quality_value;
  logic [15:0] line_index;

  tab_field_record_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .end_of_block  (end_of_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .text_out      (text_out),
    .flag_value    (flag_value),
    .quality_value (quality_value),
    .line_index    (line_index)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_word_t          byte_stream_q[$];
  tfrp_pkg::result_t   parsed_words_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  logic in_taken;
  int error_count;
  int bytes_taken;
  int bytes_pushed;
  int text_words_seen;
  int records_seen;
  int blocks_ended;

  // Parser state mirrored by the scoreboard
  tfrp_pkg::field_pos_t                 fld_pos;
  logic [63:0]                          num_acc;
  logic                                 num_ovf;
  tfrp_pkg::num_phase_t                 num_phase;
  logic                                 num_neg;
  logic [15:0]                          held_flag;
  logic [7:0]                           held_qual;
  logic [tfrp_pkg::LINE_INDEX_BITS-1:0] line_cnt;
  logic                                 seg_cut;

  task automatic clear_number();
    num_acc   = '0;
    num_ovf   = 1'b0;
    num_phase = tfrp_pkg::PH_SKIP;
    num_neg   = 1'b0;
  endtask

  task automatic clear_line();
    fld_pos   = tfrp_pkg::FP_FLAG;
    held_flag = '0;
    held_qual = '0;
    seg_cut   = 1'b0;
    clear_number();
  endtask

  function automatic logic [63:0] number_result();
    if (num_ovf) return '1;
    return num_neg ? 64'd0 - num_acc : num_acc;
  endfunction

  task automatic feed_digit_parser(input logic [7:0] b);
    logic [63:0] d;
    logic is_digit;
    logic is_ws;
    d        = {56'd0, b} - {56'd0, tfrp_pkg::CH_ZERO};
    is_digit = (b >= tfrp_pkg::CH_ZERO) && (b <= tfrp_pkg::CH_NINE);
    is_ws    = (b == tfrp_pkg::CH_SPACE) || (b == tfrp_pkg::CH_VT) ||
               (b == tfrp_pkg::CH_FF) || (b == tfrp_pkg::CH_CR);
    if (num_phase == tfrp_pkg::PH_SKIP && is_ws) begin
      // skip leading whitespace
    end else if (num_phase == tfrp_pkg::PH_SKIP &&
                 (b == tfrp_pkg::CH_PLUS || b == tfrp_pkg::CH_MINUS)) begin
      num_neg   = (b == tfrp_pkg::CH_MINUS);
      num_phase = tfrp_pkg::PH_SIGN;
    end else if (num_phase != tfrp_pkg::PH_DONE && is_digit) begin
      if (num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
        num_ovf = 1'b1;
      else
        num_acc = num_acc * 64'd10 + d;
      num_phase = tfrp_pkg::PH_DIGIT;
    end else begin
      num_phase = tfrp_pkg::PH_DONE;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eob);
    tfrp_pkg::result_t r;
    logic [31:0] wide_cnt;
    logic [63:0] v;
    r = '0;
    if (b == tfrp_pkg::CH_NL) begin
      wide_cnt        = 32'(line_cnt);
      r.result_kind   = tfrp_pkg::KIND_RECORD;
      r.flag_value    = held_flag;
      r.quality_value = held_qual;
      r.line_index    = wide_cnt[15:0];
      parsed_words_q.push_back(r);
      line_cnt = line_cnt + 1'b1;
      clear_line();
    end else if (b == tfrp_pkg::CH_TAB) begin
      v = number_result();
      if (fld_pos == tfrp_pkg::FP_FLAG) begin
        held_flag = v[15:0];
        fld_pos   = tfrp_pkg::FP_QUAL;
      end else if (fld_pos == tfrp_pkg::FP_QUAL) begin
        held_qual = v[7:0];
        fld_pos   = tfrp_pkg::FP_TEXT;
      end else begin
        r.result_kind = tfrp_pkg::KIND_TEXT;
        r.text_out    = b;
        parsed_words_q.push_back(r);
      end
      clear_number();
      seg_cut = 1'b0;
    end else if (fld_pos != tfrp_pkg::FP_TEXT) begin
      feed_digit_parser(b);
    end else if (b == tfrp_pkg::CH_NUL) begin
      seg_cut = 1'b1;
    end else if (!seg_cut) begin
      r.result_kind = tfrp_pkg::KIND_TEXT;
      r.text_out    = b;
      parsed_words_q.push_back(r);
    end
    if (eob) begin
      clear_line();
      line_cnt = '0;
      blocks_ended++;
    end
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("word %0d %s: got %h, expected %h",
                             text_words_seen + records_seen, name, got, want));
  endtask

  // Driver: present a new word once the previous one has been taken
  always @(negedge clk) begin : drive_bytes
    byte_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_stream_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = byte_stream_q.pop_front();
        in_valid     <= 1'b1;
        text_byte    <= w.b;
        end_of_block <= w.eob;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: predict on each taken byte, check each word that leaves
  always @(posedge clk) begin : watch_words
    tfrp_pkg::result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        parse_byte(text_byte, end_of_block);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (parsed_words_q.size() == 0) begin
          report_error($sformatf("unexpected word kind %b text %h flag %h", result_kind,
                                 text_out, flag_value));
        end else begin
          want = parsed_words_q.pop_front();
          check_field("result_kind", 16'(result_kind), 16'(want.result_kind));
          check_field("text_out", 16'(text_out), 16'(want.text_out));
          check_field("flag_value", flag_value, want.flag_value);
          check_field("quality_value", 16'(quality_value), 16'(want.quality_value));
          check_field("line_index", line_index, want.line_index);
        end
        if (result_kind === tfrp_pkg::KIND_RECORD) records_seen++;
        else text_words_seen++;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eob);
    byte_word_t w;
    w.b   = b;
    w.eob = eob;
    byte_stream_q.push_back(w);
    bytes_pushed++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // Random byte, now and then closing the block mid-line
  task automatic emit(input logic [7:0] b);
    push_byte(b, $urandom_range(0, 299) == 0);
  endtask

  function automatic logic [7:0] field_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == tfrp_pkg::CH_TAB || b == tfrp_pkg::CH_NL) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 3))
      0:       return tfrp_pkg::CH_SPACE;
      1:       return tfrp_pkg::CH_VT;
      2:       return tfrp_pkg::CH_FF;
      default: return tfrp_pkg::CH_CR;
    endcase
  endfunction

  task automatic gen_number();
    int sel;
    string lim;
    sel = $urandom_range(0, 99);
    lim = "1844674407370955161";
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) emit(ws_byte());
    case ($urandom_range(0, 3))
      0: emit(tfrp_pkg::CH_PLUS);
      1: emit(tfrp_pkg::CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) emit(field_byte());
    if (sel < 10) begin
      // no digits
    end else if (sel < 75) begin
      repeat ($urandom_range(1, 5)) emit(tfrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (sel < 88) begin
      // straddle the 64-bit limit
      for (int i = 0; i < lim.len(); i++) emit(lim[i]);
      emit(tfrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      repeat ($urandom_range(17, 24)) emit(tfrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 2)) emit(field_byte());
  endtask

  task automatic gen_segment();
    int len;
    int nul_at;
    len    = $urandom_range(0, 4);
    nul_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : -1;
    for (int k = 0; k <= len; k++) begin
      if (k == nul_at) emit(tfrp_pkg::CH_NUL);
      if (k < len) emit(field_byte());
    end
  endtask

  task automatic gen_record();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      gen_number();
      emit(tfrp_pkg::CH_TAB);
      gen_number();
      emit(tfrp_pkg::CH_TAB);
      gen_segment();
      repeat ($urandom_range(0, 2)) begin
        emit(tfrp_pkg::CH_TAB);
        gen_segment();
      end
      push_byte(tfrp_pkg::CH_NL, $urandom_range(0, 99) < 8);
    end else if (kind < 90) begin
      gen_number();
      if ($urandom_range(0, 1) == 1) begin
        emit(tfrp_pkg::CH_TAB);
        gen_number();
      end
      push_byte(tfrp_pkg::CH_NL, $urandom_range(0, 99) < 8);
    end else begin
      repeat ($urandom_range(1, 6)) emit(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int phase_start;
    int n;
    rst           = 1'b1;
    in_valid      = 1'b0;
    text_byte     = '0;
    end_of_block  = 1'b0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    error_count   = 0;
    bytes_taken   = 0;
    bytes_pushed  = 0;
    text_words_seen = 0;
    records_seen  = 0;
    blocks_ended  = 0;
    line_cnt      = '0;
    clear_line();
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 13 : 0;
      phase_start   = bytes_pushed;
      if (ph == 0) begin
        // sign, minus, NUL cut in text, empty fields, 0xFF, unterminated line
        push_str(" -5\t+7\ta");
        push_byte(tfrp_pkg::CH_NUL, 1'b0);
        push_str("b\tc\n");
        push_str("\t\n");
        push_byte(8'hFF, 1'b0);
        push_str("\t0\t");
        push_byte(8'hFF, 1'b0);
        push_str("\n12\t3\t");
        push_byte("z", 1'b1);
      end
      while (bytes_pushed - phase_start < 267) gen_record();
      while (byte_stream_q.size() > 0 || in_valid) @(posedge clk);
    end

    n = 0;
    while (parsed_words_q.size() > 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
    if (parsed_words_q.size() > 0)
      report_error($sformatf("%0d expected words never arrived", parsed_words_q.size()));

    $display("Run: %0d bytes taken across %0d block ends", bytes_taken, blocks_ended);
    $display("Run: %0d text words and %0d records checked, %0d errors",
             text_words_seen, records_seen, error_count);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout: run did not finish");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tfrp_pkg.sv
hdl/tfrp_in_stage.sv
hdl/tfrp_parse.sv
hdl/tfrp_out_stage.sv
hdl/tab_field_record_parser.sv
hdl/tfrp_checker.sv
tb/testbench.sv
